FILE: hw/rtl/gpf_pkg.sv
`default_nettype none

package gpf_pkg;

    // Widths and constants shared by the pair finder
    localparam int VALUE_BITS_DEF   = 8;
    localparam int FIELD_BITS       = 8;
    localparam int PRIME_TABLE_SIZE = 1 << FIELD_BITS;
    localparam int PAIR_MIN_SUM     = 4;
    localparam int FIRST_ODD_PRIME  = 3;
    localparam int PRIME_STEP       = 2;

    // Sieve worked out at elaboration: bit n set when n is an odd prime
    function automatic logic [PRIME_TABLE_SIZE-1:0] build_odd_prime_mask();
        logic [PRIME_TABLE_SIZE-1:0] m;
        int n;
        int d;
        int k;
        m = '0;
        for (n = FIRST_ODD_PRIME; n < PRIME_TABLE_SIZE; n = n + PRIME_STEP) begin
            m[n] = 1'b1;
        end
        for (d = FIRST_ODD_PRIME; d * d < PRIME_TABLE_SIZE; d = d + PRIME_STEP) begin
            for (k = d * d; k < PRIME_TABLE_SIZE; k = k + d) begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    localparam logic [PRIME_TABLE_SIZE-1:0] ODD_PRIME_MASK = build_odd_prime_mask();

endpackage

`default_nettype wire

FILE: hw/rtl/goldbach_pair_finder_unit.sv
`default_nettype none

// Goldbach pair finder.
// Input channel (i_valid / o_ready) takes one beat: a value and a list-end
// flag. The flag is accepted and has no effect on the results.
// Output channel (o_valid / i_ready) gives one beat per ordered pair (p, q)
// of odd primes with p + q equal to the value, p rising; o_run_last marks
// the final pair of a value. Odd values and values of 4 or less give none.
// Only the low VALUE_BITS bits of the value are used.
// Timing: one candidate p is tested per cycle, save while a hit waits on a
// full output register, by a single shared check unit (subtract plus
// prime-table look-up). An odd value or one of 4 or less is dropped
// without leaving idle. The first pair is sent to the output register
// once a second pair is found or the scan ends (the last pair is held
// back to mark it).
// o_ready is high only between values.
// A stalled receiver holds the output register; the scan then waits on the
// next hit and resumes when the register drains.
// Reset (synchronous, active low) drops any value in progress and any
// undelivered beat.
module goldbach_pair_finder_unit #(
    parameter int VALUE_BITS = gpf_pkg::VALUE_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [gpf_pkg::FIELD_BITS-1:0] i_value,
    input  wire logic                       i_list_end,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [gpf_pkg::FIELD_BITS-1:0] o_first_prime,
    output logic      [gpf_pkg::FIELD_BITS-1:0] o_second_prime,
    output logic      [gpf_pkg::FIELD_BITS-1:0] o_total,
    output logic                            o_run_last
);
    import gpf_pkg::*;

    localparam int VB = VALUE_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // Sequencer state
    logic [1:0]    r_state, n_state;
    logic [VB-1:0] r_v, n_v;
    logic [VB-1:0] r_p, n_p;
    logic [VB-1:0] r_pend_p, n_pend_p;
    logic [VB-1:0] r_pend_q, n_pend_q;
    logic          r_have_pend, n_have_pend;

    // Output register
    logic          r_out_valid, n_out_valid;
    logic [VB-1:0] r_out_p, n_out_p;
    logic [VB-1:0] r_out_q, n_out_q;
    logic [VB-1:0] r_out_t, n_out_t;
    logic          r_out_last, n_out_last;

    logic [VB-1:0] v_in;
    logic          start_ok;
    logic          in_beat;
    logic [VB:0]   p_next;
    logic          scan_end;
    logic [VB-1:0] q;
    logic          hit;
    logic          out_free;
    logic          push;
    logic          push_last;

    // The list-end flag rides along with the value and changes nothing
    logic          list_end_unused;
    assign list_end_unused = i_list_end;

    gpf_pair_check #(
        .VALUE_BITS (VALUE_BITS)
    ) u_check (
        .i_sum     (r_v),
        .i_cand    (r_p),
        .o_partner (q),
        .o_hit     (hit)
    );

    assign o_ready  = (r_state == ST_IDLE);
    assign in_beat  = i_valid && o_ready;
    assign v_in     = i_value[VB-1:0];
    assign start_ok = !v_in[0] && (FIELD_BITS'(v_in) > FIELD_BITS'(PAIR_MIN_SUM));
    assign p_next   = {1'b0, r_p} + (VB+1)'(PRIME_STEP);
    assign scan_end = (p_next >= {1'b0, r_v});
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_p         = r_p;
        n_pend_p    = r_pend_p;
        n_pend_q    = r_pend_q;
        n_have_pend = r_have_pend;
        push        = 1'b0;
        push_last   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat && start_ok) begin
                    n_v         = v_in;
                    n_p         = VB'(FIRST_ODD_PRIME);
                    n_have_pend = 1'b0;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // A new hit displaces the held pair, which then is not last
                if (!(hit && r_have_pend && !out_free)) begin
                    push = hit && r_have_pend;
                    if (hit) begin
                        n_pend_p    = r_p;
                        n_pend_q    = q;
                        n_have_pend = 1'b1;
                    end
                    if (scan_end) begin
                        n_state = (r_have_pend || hit) ? ST_FLUSH : ST_IDLE;
                    end else begin
                        n_p = p_next[VB-1:0];
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    push        = 1'b1;
                    push_last   = 1'b1;
                    n_have_pend = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_out_p     = r_out_p;
        n_out_q     = r_out_q;
        n_out_t     = r_out_t;
        n_out_last  = r_out_last;
        if (push) begin
            n_out_valid = 1'b1;
            n_out_p     = r_pend_p;
            n_out_q     = r_pend_q;
            n_out_t     = r_v;
            n_out_last  = push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have_pend <= n_have_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_p        <= n_p;
        r_pend_p   <= n_pend_p;
        r_pend_q   <= n_pend_q;
        r_out_p    <= n_out_p;
        r_out_q    <= n_out_q;
        r_out_t    <= n_out_t;
        r_out_last <= n_out_last;
    end

    assign o_valid        = r_out_valid;
    assign o_first_prime  = FIELD_BITS'(r_out_p);
    assign o_second_prime = FIELD_BITS'(r_out_q);
    assign o_total        = FIELD_BITS'(r_out_t);
    assign o_run_last     = r_out_last;

`ifndef SYNTHESIS
    a_sum_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_p + r_out_q) == r_out_t)
        else $error("pair does not add up to its total");

    a_both_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_p[0] && r_out_q[0]))
        else $error("pair member is even");

    a_cand_below_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_p < r_v))
        else $error("candidate has passed the value");

    a_flush_has_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> r_have_pend)
        else $error("flush without a held pair");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_last) |=> (r_state == ST_IDLE) && !r_have_pend)
        else $error("sequencer busy after last pair");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/gpf_pair_check.sv
`default_nettype none

// Shared test unit: partner = sum - candidate, hit when both are odd primes
module gpf_pair_check #(
    parameter int VALUE_BITS = gpf_pkg::VALUE_BITS_DEF
) (
    input  wire logic [VALUE_BITS-1:0] i_sum,
    input  wire logic [VALUE_BITS-1:0] i_cand,
    output logic      [VALUE_BITS-1:0] o_partner,
    output logic                       o_hit
);
    import gpf_pkg::*;

    logic [VALUE_BITS-1:0] partner;

    assign partner   = i_sum - i_cand;
    assign o_partner = partner;
    assign o_hit     = ODD_PRIME_MASK[FIELD_BITS'(i_cand)] &
                       ODD_PRIME_MASK[FIELD_BITS'(partner)];

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int FB              = gpf_pkg::FIELD_BITS;
    localparam int VALUE_BITS      = gpf_pkg::VALUE_BITS_DEF;
    localparam int MAX_PAIRS       = 40;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int SETTLE_CYCLES   = 300;
    localparam int RANDOM_ITEMS    = 400;
    localparam int HOLD_AT_ITEM    = 120;

    // How a row of the directed table gets its expectation
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_SINGLE
    } t_row_kind;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    typedef struct packed {
        logic [FB-1:0] first_prime;
        logic [FB-1:0] second_prime;
        logic [FB-1:0] total;
        logic          run_last;
    } t_pair_beat;

    typedef struct {
        logic [FB-1:0] value;
        logic          list_end;
        t_row_kind     kind;
        logic [FB-1:0] first_prime;
        logic [FB-1:0] second_prime;
    } t_directed_row;

    // Clock and DUT ports; every input starts at a known level
    logic          i_clk      = 1'b0;
    logic          i_rst_n    = 1'b0;
    logic          i_valid    = 1'b0;
    logic [FB-1:0] i_value    = '0;
    logic          i_list_end = 1'b0;
    logic          i_ready    = 1'b0;
    logic          o_ready;
    logic          o_valid;
    logic [FB-1:0] o_first_prime;
    logic [FB-1:0] o_second_prime;
    logic [FB-1:0] o_total;
    logic          o_run_last;

    t_pair_beat    expected_pairs [$];
    t_directed_row directed_rows [$];
    int            fail_count    = 0;
    int            hold_requests = 0;
    int            burst_left    = 0;

    goldbach_pair_finder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .i_list_end    (i_list_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_first_prime (o_first_prime),
        .o_second_prime(o_second_prime),
        .o_total       (o_total),
        .o_run_last    (o_run_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Odd primality by trial division over odd divisors
    function automatic bit is_odd_prime(input int n);
        int d;
        if (n < gpf_pkg::FIRST_ODD_PRIME || (n % 2) == 0) begin
            return 1'b0;
        end
        for (d = 3; d * d <= n; d = d + 2) begin
            if ((n % d) == 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Work out the ordered odd-prime pairs, at most MAX_PAIRS, that sum to
    // the masked value, queue them in rising order of p; mark the final one.
    task automatic queue_pairs_for(input logic [FB-1:0] raw, output int found);
        int         v;
        int         p;
        int         i;
        int         hits [$];
        t_pair_beat b;
        found = 0;
        v = int'(raw) & ((1 << VALUE_BITS) - 1);
        if ((v % 2) == 1 || v <= gpf_pkg::PAIR_MIN_SUM) begin
            return;
        end
        for (p = gpf_pkg::FIRST_ODD_PRIME; p < v; p = p + gpf_pkg::PRIME_STEP) begin
            if (is_odd_prime(p) && is_odd_prime(v - p) && hits.size() < MAX_PAIRS) begin
                hits.push_back(p);
            end
        end
        for (i = 0; i < hits.size(); i++) begin
            b.first_prime  = hits[i][FB-1:0];
            b.second_prime = FB'(v - hits[i]);
            b.total        = FB'(v);
            b.run_last     = (i == hits.size() - 1);
            expected_pairs.push_back(b);
        end
        found = hits.size();
    endtask

    task automatic add_row(input logic [FB-1:0] v, input logic le, input t_row_kind kind,
                           input logic [FB-1:0] p, input logic [FB-1:0] q);
        t_directed_row r;
        r.value        = v;
        r.list_end     = le;
        r.kind         = kind;
        r.first_prime  = p;
        r.second_prime = q;
        directed_rows.push_back(r);
    endtask

    // Offer one input beat from the current rising edge and hold it until
    // it is taken; return at the edge of acceptance.
    task automatic send_beat(input logic [FB-1:0] v, input logic le);
        i_valid    <= 1'b1;
        i_value    <= v;
        i_list_end <= le;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Burst pacing: keep valid high within a burst; between bursts drop it
    // for a random gap, or for none. Some gaps are long enough to leave the block fully idle.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        case ($urandom_range(0, 7))
            0, 1:    gap = 0;
            2:       gap = $urandom_range(20, 160);
            default: gap = $urandom_range(1, 6);
        endcase
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver: change stall pattern every so often; on request hold off for
    // a long stretch so that the block backs up and drops o_ready.
    int       rx_hold_left = 0;
    int       rx_served    = 0;
    int       rx_mode_left = 0;
    t_rx_mode rx_mode      = RX_ALWAYS;

    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_ready <= 1'b0;
        end else if (rx_served != hold_requests) begin
            rx_served    = hold_requests;
            rx_hold_left = HOLD_OFF_CYCLES;
            i_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(32, 256);
            end else begin
                rx_mode_left = rx_mode_left - 1;
            end
            case (rx_mode)
                RX_ALWAYS: i_ready <= 1'b1;
                RX_RANDOM: i_ready <= $urandom_range(0, 1);
                RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                default:   i_ready <= ~i_ready;
            endcase
        end
    end

    // Scoreboard: every output beat must match the oldest expected pair
    always @(posedge i_clk) begin
        t_pair_beat exp_b;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pairs.size() == 0) begin
                $error("unexpected beat: p=%0d q=%0d total=%0d last=%0d",
                       o_first_prime, o_second_prime, o_total, o_run_last);
                fail_count++;
            end else begin
                exp_b = expected_pairs.pop_front();
                if (o_first_prime !== exp_b.first_prime) begin
                    $error("first_prime: expected %0d, got %0d",
                           exp_b.first_prime, o_first_prime);
                    fail_count++;
                end
                if (o_second_prime !== exp_b.second_prime) begin
                    $error("second_prime: expected %0d, got %0d",
                           exp_b.second_prime, o_second_prime);
                    fail_count++;
                end
                if (o_total !== exp_b.total) begin
                    $error("total: expected %0d, got %0d", exp_b.total, o_total);
                    fail_count++;
                end
                if (o_run_last !== exp_b.run_last) begin
                    $error("run_last: expected %0d, got %0d", exp_b.run_last, o_run_last);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random beats, drain
    initial begin
        int            found;
        int            sent;
        bit            held;
        logic [FB-1:0] v;
        logic          le;
        t_pair_beat    b;
        sent = 0;
        held = 1'b0;

        // Directed table: values at and around the no-result boundary, the
        // smallest pair, odd extremes, the largest even value, list_end set
        add_row(8'd0,   1'b0, ROW_NONE,    8'd0, 8'd0);
        add_row(8'd1,   1'b0, ROW_NONE,    8'd0, 8'd0);
        add_row(8'd2,   1'b0, ROW_NONE,    8'd0, 8'd0);
        add_row(8'd3,   1'b0, ROW_NONE,    8'd0, 8'd0);
        add_row(8'd4,   1'b0, ROW_NONE,    8'd0, 8'd0);
        add_row(8'd5,   1'b0, ROW_NONE,    8'd0, 8'd0);
        add_row(8'd6,   1'b0, ROW_SINGLE,  8'd3, 8'd3);
        add_row(8'd7,   1'b0, ROW_NONE,    8'd0, 8'd0);
        add_row(8'd8,   1'b0, ROW_PREDICT, 8'd0, 8'd0);
        add_row(8'd10,  1'b0, ROW_PREDICT, 8'd0, 8'd0);
        add_row(8'd12,  1'b0, ROW_PREDICT, 8'd0, 8'd0);
        add_row(8'd254, 1'b0, ROW_PREDICT, 8'd0, 8'd0);
        add_row(8'd255, 1'b0, ROW_NONE,    8'd0, 8'd0);
        add_row(8'd253, 1'b0, ROW_NONE,    8'd0, 8'd0);
        add_row(8'd252, 1'b1, ROW_PREDICT, 8'd0, 8'd0);
        add_row(8'd128, 1'b0, ROW_PREDICT, 8'd0, 8'd0);
        add_row(8'd170, 1'b0, ROW_PREDICT, 8'd0, 8'd0);
        add_row(8'd86,  1'b0, ROW_PREDICT, 8'd0, 8'd0);
        add_row(8'd100, 1'b1, ROW_PREDICT, 8'd0, 8'd0);
        add_row(8'd9,   1'b1, ROW_NONE,    8'd0, 8'd0);
        add_row(8'd6,   1'b1, ROW_SINGLE,  8'd3, 8'd3);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_beat(directed_rows[k].value, directed_rows[k].list_end);
            case (directed_rows[k].kind)
                ROW_PREDICT: queue_pairs_for(directed_rows[k].value, found);
                ROW_SINGLE: begin
                    b.first_prime  = directed_rows[k].first_prime;
                    b.second_prime = directed_rows[k].second_prime;
                    b.total        = directed_rows[k].value;
                    b.run_last     = 1'b1;
                    expected_pairs.push_back(b);
                end
                default: ;
            endcase
            pace_sender();
        end

        // Random part: mostly even values above the boundary, small ones
        // favoured to keep the scan short; the rest is any 8-bit value
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 3) == 0) begin
                    v = FB'(2 * $urandom_range(3, 127));
                end else begin
                    v = FB'(2 * $urandom_range(3, 40));
                end
            end else begin
                v = FB'($urandom_range(0, 255));
            end
            le = ($urandom_range(0, 15) == 0);
            send_beat(v, le);
            queue_pairs_for(v, found);
            sent++;
            // Ask once for a long receiver hold-off while beats keep coming
            if (!held && sent == HOLD_AT_ITEM) begin
                held = 1'b1;
                hold_requests++;
            end
            pace_sender();
        end
        i_valid <= 1'b0;

        // Drain every expected pair, then let the block settle
        while (expected_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
